FILE: src/audio_peak_level_meter_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the audio peak level meter
// Concurrent checks clocked on clk and held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef AUDIO_PEAK_LEVEL_METER_TOP_ASSERT_SVH
`define AUDIO_PEAK_LEVEL_METER_TOP_ASSERT_SVH

// same-cycle implication
`define APM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define APM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/apm_pkg.sv
// ---------------------------------------------------------------------------
// Audio peak level meter package
// Payload types, queue command, configuration set and level classifier.
// ---------------------------------------------------------------------------
package apm_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SHOWN_BARS  = 5;
    localparam int BAR_HEIGHTS_W = SHOWN_BARS * 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 3;

    localparam logic [2:0] LEVEL_QUIET = 3'd0;
    localparam logic [2:0] LEVEL_ONE   = 3'd1;
    localparam logic [2:0] LEVEL_TWO   = 3'd2;
    localparam logic [2:0] LEVEL_THREE = 3'd3;
    localparam logic [2:0] LEVEL_FOUR  = 3'd4;
    localparam logic [2:0] LEVEL_LOUD  = 3'd5;

    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_REPORT = 2'd2,
        OP_UNUSED = 2'd3
    } op_e_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SILENCE_CODE  = 3'd0,
        REG_LEVEL_ONE     = 3'd1,
        REG_LEVEL_TWO     = 3'd2,
        REG_LEVEL_THREE   = 3'd3,
        REG_LEVEL_FOUR    = 3'd4,
        REG_LOUD          = 3'd5,
        REG_FRAME_LENGTH  = 3'd6,
        REG_UPDATE_MS     = 3'd7
    } reg_idx_e_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] sample;
    } in_item_t;

    typedef struct packed {
        logic                     result_kind;
        logic [2:0]               frame_level;
        logic [11:0]              frame_peak;
        logic                     alert;
        logic                     bars_updated;
        logic [BAR_HEIGHTS_W-1:0] bar_heights;
        logic [11:0]              report_peak;
        logic [31:0]              loud_sum;
        logic [23:0]              loud_count;
        logic [39:0]              sample_sum;
        logic [31:0]              sample_count;
    } out_item_t;

    typedef struct packed {
        logic [11:0] silence_code;
        logic [11:0] level_one_threshold;
        logic [11:0] level_two_threshold;
        logic [11:0] level_three_threshold;
        logic [11:0] level_four_threshold;
        logic [11:0] loud_threshold;
        logic [7:0]  frame_length;
        logic [15:0] bar_interval;
    } cfg_t;

    typedef struct packed {
        op_e_t       op;
        logic [11:0] amp;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_entry_t;

    function automatic logic [2:0] classify(input logic [11:0] peak, input cfg_t cfg);
        logic [2:0] level;
        if (peak < cfg.level_one_threshold)
            level = LEVEL_QUIET;
        else if (peak < cfg.level_two_threshold)
            level = LEVEL_ONE;
        else if (peak < cfg.level_three_threshold)
            level = LEVEL_TWO;
        else if (peak < cfg.level_four_threshold)
            level = LEVEL_THREE;
        else if (peak < cfg.loud_threshold)
            level = LEVEL_FOUR;
        else
            level = LEVEL_LOUD;
        return level;
    endfunction

endpackage

FILE: src/apm_if.sv
// ---------------------------------------------------------------------------
// Audio peak level meter channels
// Valid/ready stream interfaces for input items and result items.
// ---------------------------------------------------------------------------
interface apm_item_if;
    logic               valid;
    logic               ready;
    apm_pkg::in_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface apm_result_if;
    logic               valid;
    logic               ready;
    apm_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: src/apm_front.sv
// ---------------------------------------------------------------------------
// Audio peak level meter front end
// Accepts items, drops unused operations and forms the sample amplitude.
// ---------------------------------------------------------------------------
module apm_front (
    apm_item_if.sink          items,
    input  logic [11:0]       silence_code,
    input  logic              full,
    output apm_pkg::q_entry_t push
);

    logic [11:0] sample;
    logic        known_op;

    assign sample      = items.payload.sample;
    assign items.ready = !full;

    always_comb
    begin
        case (items.payload.operation) inside
            apm_pkg::OP_SAMPLE, apm_pkg::OP_TICK, apm_pkg::OP_REPORT: known_op = 1'b1;
            default: known_op = 1'b0;
        endcase
    end

    always_comb
    begin
        push.valid   = items.valid && !full && known_op;
        push.cmd.op  = apm_pkg::op_e_t'(items.payload.operation);
        push.cmd.amp = (sample >= silence_code) ? (sample - silence_code)
                                                : (silence_code - sample);
    end

endmodule

FILE: src/apm_queue.sv
// ---------------------------------------------------------------------------
// Audio peak level meter command queue
// Short first-in first-out buffer between the front end and the back end.
// ---------------------------------------------------------------------------
`include "audio_peak_level_meter_top_assert.svh"

module apm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  apm_pkg::q_entry_t push,
    output logic              full,
    output apm_pkg::q_entry_t head,
    input  logic              pop
);

    localparam logic [apm_pkg::QCNT_W-1:0] DEPTH = apm_pkg::QCNT_W'(apm_pkg::QUEUE_DEPTH);

    apm_pkg::cmd_t                 entry_reg [apm_pkg::QUEUE_DEPTH];
    logic [apm_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [apm_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [apm_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                          do_push, do_pop;

    assign full       = (count_reg == DEPTH);
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push.cmd;
    end

    `APM_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= DEPTH, "queue count past depth")
    `APM_ASSERT_NOW(a_pop_nonempty, pop, count_reg != '0, "pop from empty queue")
    `APM_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1,
        "queue count did not advance on push")
    `APM_ASSERT_NOW(a_ptr_gap, 1'b1,
        (count_reg == DEPTH) || (count_reg == '0) ||
        (wr_ptr_reg - rd_ptr_reg) == count_reg[apm_pkg::QPTR_W-1:0],
        "queue pointers disagree with count")

endmodule

FILE: src/apm_back.sv
// ---------------------------------------------------------------------------
// Audio peak level meter back end
// Frame tracking, level classification, statistics and result register.
// ---------------------------------------------------------------------------
`include "audio_peak_level_meter_top_assert.svh"

module apm_back #(
    parameter int BAR_COLUMNS  = 5,
    parameter int ALERT_FRAMES = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  apm_pkg::cfg_t     cfg,
    input  apm_pkg::q_entry_t head,
    output logic              pop,
    apm_result_if.source      results
);

    localparam int         BAR_W       = BAR_COLUMNS * 3;
    localparam int         SHOWN       = (BAR_COLUMNS < apm_pkg::SHOWN_BARS) ? BAR_COLUMNS
                                                                              : apm_pkg::SHOWN_BARS;
    localparam int         SHOWN_W     = SHOWN * 3;
    localparam logic [7:0] ALERT_LIMIT = 8'(ALERT_FRAMES);

    logic [7:0]       frame_cnt_reg, frame_cnt_next;
    logic [11:0]      run_peak_reg, run_peak_next;
    logic [15:0]      ms_reg, ms_next;
    logic [BAR_W-1:0] bars_reg, bars_next;
    logic [7:0]       tally_reg, tally_next;
    logic [11:0]      peak_rep_reg, peak_rep_next;
    logic [31:0]      loud_sum_reg, loud_sum_next;
    logic [23:0]      loud_cnt_reg, loud_cnt_next;
    logic [39:0]      amp_sum_reg, amp_sum_next;
    logic [31:0]      smp_cnt_reg, smp_cnt_next;
    logic             out_valid_reg, out_valid_next;
    apm_pkg::out_item_t out_reg, out_next;

    logic [7:0]       frame_cnt_inc, flen, tally_inc;
    logic [11:0]      peak;
    logic [2:0]       level;
    logic             frame_end, loud, alert, shift;
    logic [40:0]      amp_sum_add;
    logic [32:0]      smp_cnt_add, loud_sum_add;
    logic [24:0]      loud_cnt_add;
    logic [BAR_W-1:0] bars_shifted;
    logic [apm_pkg::BAR_HEIGHTS_W-1:0] heights_now, heights_shifted;

    assign pop             = head.valid && (!out_valid_reg || results.ready);
    assign results.valid   = out_valid_reg;
    assign results.payload = out_reg;

    always_comb
    begin
        frame_cnt_inc = frame_cnt_reg + 8'd1;
        flen          = (cfg.frame_length == 8'd0) ? 8'd1 : cfg.frame_length;
        frame_end     = (frame_cnt_inc >= flen);
        peak          = (head.cmd.amp > run_peak_reg) ? head.cmd.amp : run_peak_reg;
        level         = apm_pkg::classify(peak, cfg);
        loud          = (level == apm_pkg::LEVEL_LOUD);
        tally_inc     = tally_reg + 8'd1;
        alert         = loud && (tally_inc >= ALERT_LIMIT);
        shift         = (ms_reg >= cfg.bar_interval);
        amp_sum_add   = {1'b0, amp_sum_reg} + 41'(head.cmd.amp);
        smp_cnt_add   = {1'b0, smp_cnt_reg} + 33'd1;
        loud_sum_add  = {1'b0, loud_sum_reg} + 33'(peak);
        loud_cnt_add  = {1'b0, loud_cnt_reg} + 25'd1;
        bars_shifted  = {level, bars_reg[BAR_W-1:3]};
        heights_now     = apm_pkg::BAR_HEIGHTS_W'(bars_reg[SHOWN_W-1:0]);
        heights_shifted = apm_pkg::BAR_HEIGHTS_W'(bars_shifted[SHOWN_W-1:0]);
    end

    always_comb
    begin
        frame_cnt_next = frame_cnt_reg;
        run_peak_next  = run_peak_reg;
        ms_next        = ms_reg;
        bars_next      = bars_reg;
        tally_next     = tally_reg;
        peak_rep_next  = peak_rep_reg;
        loud_sum_next  = loud_sum_reg;
        loud_cnt_next  = loud_cnt_reg;
        amp_sum_next   = amp_sum_reg;
        smp_cnt_next   = smp_cnt_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_next       = out_reg;

        if (pop)
        begin
            case (head.cmd.op)
                apm_pkg::OP_SAMPLE:
                begin
                    amp_sum_next = amp_sum_add[40] ? '1 : amp_sum_add[39:0];
                    smp_cnt_next = smp_cnt_add[32] ? '1 : smp_cnt_add[31:0];
                    if (frame_end)
                    begin
                        frame_cnt_next = '0;
                        run_peak_next  = '0;
                        if (peak > peak_rep_reg)
                            peak_rep_next = peak;
                        if (loud)
                        begin
                            loud_sum_next = loud_sum_add[32] ? '1 : loud_sum_add[31:0];
                            loud_cnt_next = loud_cnt_add[24] ? '1 : loud_cnt_add[23:0];
                            tally_next    = alert ? '0 : tally_inc;
                        end
                        if (shift)
                        begin
                            bars_next = bars_shifted;
                            ms_next   = '0;
                        end
                        out_valid_next       = 1'b1;
                        out_next             = '0;
                        out_next.result_kind = apm_pkg::KIND_FRAME;
                        out_next.frame_level = level;
                        out_next.frame_peak  = peak;
                        out_next.alert       = alert;
                        out_next.bars_updated = shift;
                        out_next.bar_heights = shift ? heights_shifted : heights_now;
                    end
                    else
                    begin
                        frame_cnt_next = frame_cnt_inc;
                        run_peak_next  = peak;
                    end
                end
                apm_pkg::OP_TICK:
                begin
                    if (ms_reg != '1)
                        ms_next = ms_reg + 16'd1;
                end
                apm_pkg::OP_REPORT:
                begin
                    out_valid_next        = 1'b1;
                    out_next              = '0;
                    out_next.result_kind  = apm_pkg::KIND_REPORT;
                    out_next.bar_heights  = heights_now;
                    out_next.report_peak  = peak_rep_reg;
                    out_next.loud_sum     = loud_sum_reg;
                    out_next.loud_count   = loud_cnt_reg;
                    out_next.sample_sum   = amp_sum_reg;
                    out_next.sample_count = smp_cnt_reg;
                    peak_rep_next = '0;
                    loud_sum_next = '0;
                    loud_cnt_next = '0;
                    amp_sum_next  = '0;
                    smp_cnt_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_cnt_reg <= '0;
            run_peak_reg  <= '0;
            ms_reg        <= '0;
            bars_reg      <= '0;
            tally_reg     <= '0;
            peak_rep_reg  <= '0;
            loud_sum_reg  <= '0;
            loud_cnt_reg  <= '0;
            amp_sum_reg   <= '0;
            smp_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            frame_cnt_reg <= frame_cnt_next;
            run_peak_reg  <= run_peak_next;
            ms_reg        <= ms_next;
            bars_reg      <= bars_next;
            tally_reg     <= tally_next;
            peak_rep_reg  <= peak_rep_next;
            loud_sum_reg  <= loud_sum_next;
            loud_cnt_reg  <= loud_cnt_next;
            amp_sum_reg   <= amp_sum_next;
            smp_cnt_reg   <= smp_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    `APM_ASSERT_NOW(a_tally_bound, 1'b1, tally_reg < ALERT_LIMIT, "loud tally reached alert limit")
    `APM_ASSERT_NEXT(a_stall_hold, out_valid_reg && !results.ready,
        out_valid_reg && $stable(out_reg), "result dropped while stalled")
    `APM_ASSERT_NEXT(a_shift_clears_ms,
        pop && head.cmd.op == apm_pkg::OP_SAMPLE && frame_end && shift,
        ms_reg == '0, "bar shift left millisecond count")
    `APM_ASSERT_NEXT(a_report_clears, pop && head.cmd.op == apm_pkg::OP_REPORT,
        smp_cnt_reg == '0 && amp_sum_reg == '0 && peak_rep_reg == '0,
        "report left statistics behind")

endmodule

FILE: src/audio_peak_level_meter_top.sv
// ---------------------------------------------------------------------------
// Audio peak level meter
// Per-frame peak levels, loud-frame alerts, bar history and statistics.
//
// Channel    Dir  Handshake     Payload
// items      in   valid/ready   operation, sample
// results    out  valid/ready   frame result or statistics report
// cfg_*      in   write enable  register index, register data
//
// One item per cycle while items.ready is high, which falls when the queue is
// full; an item passes the command queue and then the result register.
// Reset loads register defaults and clears state except queue entries and
// result payload; no clearing pass. A four-entry queue absorbs result stalls.
// ---------------------------------------------------------------------------
module audio_peak_level_meter_top #(
    parameter int BAR_COLUMNS  = 5,
    parameter int ALERT_FRAMES = 20
) (
    input  logic                           clk,
    input  logic                           rst_n,
    apm_item_if.sink                       items,
    apm_result_if.source                   results,
    input  logic                           cfg_wr_en,
    input  logic [apm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [apm_pkg::CFG_DATA_W-1:0] cfg_data
);

    apm_pkg::cfg_t     cfg_reg;
    apm_pkg::q_entry_t push, head;
    logic              full, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.silence_code          <= 12'd2048;
            cfg_reg.level_one_threshold   <= 12'd100;
            cfg_reg.level_two_threshold   <= 12'd250;
            cfg_reg.level_three_threshold <= 12'd350;
            cfg_reg.level_four_threshold  <= 12'd450;
            cfg_reg.loud_threshold        <= 12'd750;
            cfg_reg.frame_length          <= 8'd79;
            cfg_reg.bar_interval          <= 16'd75;
        end
        else if (cfg_wr_en)
        begin
            case (apm_pkg::reg_idx_e_t'(cfg_index))
                apm_pkg::REG_SILENCE_CODE:  cfg_reg.silence_code          <= cfg_data[11:0];
                apm_pkg::REG_LEVEL_ONE:     cfg_reg.level_one_threshold   <= cfg_data[11:0];
                apm_pkg::REG_LEVEL_TWO:     cfg_reg.level_two_threshold   <= cfg_data[11:0];
                apm_pkg::REG_LEVEL_THREE:   cfg_reg.level_three_threshold <= cfg_data[11:0];
                apm_pkg::REG_LEVEL_FOUR:    cfg_reg.level_four_threshold  <= cfg_data[11:0];
                apm_pkg::REG_LOUD:          cfg_reg.loud_threshold        <= cfg_data[11:0];
                apm_pkg::REG_FRAME_LENGTH:  cfg_reg.frame_length          <= cfg_data[7:0];
                apm_pkg::REG_UPDATE_MS:     cfg_reg.bar_interval          <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    apm_front u_front (
        .items        (items),
        .silence_code (cfg_reg.silence_code),
        .full         (full),
        .push         (push)
    );

    apm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .head  (head),
        .pop   (pop)
    );

    apm_back #(
        .BAR_COLUMNS  (BAR_COLUMNS),
        .ALERT_FRAMES (ALERT_FRAMES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .head    (head),
        .pop     (pop),
        .results (results)
    );

endmodule

FILE: dv/tb_top.sv
// ---------------------------------------------------------------------------
// Audio peak level meter testbench
// Drives sample, tick, report and unused items through the item channel and
// checks every frame result and statistics report against a cycle-free level
// meter predictor. A short stimulus table covers reset, extreme samples and
// the level boundaries. Randomized mixes then run under several register
// settings: the floor and ceiling values, zero frame length and interval,
// and unordered thresholds. A long receiver hold-off forces back-pressure.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int BAR_COLUMNS    = 5;
    localparam int ALERT_FRAMES   = 20;
    localparam int RESET_CYCLES   = 2;
    localparam int LONG_HOLD      = 150;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [11:0]        SILENCE_MID = 12'd2048;
    localparam apm_pkg::out_item_t NO_PIN      = '0;
    localparam apm_pkg::cfg_t FACTORY_SETTING = {12'd2048, 12'd100, 12'd250, 12'd350, 12'd450,
                                                 12'd750, 8'd79, 16'd75};

    typedef struct packed {
        apm_pkg::in_item_t  item;
        logic               pinned;
        apm_pkg::out_item_t reading;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic                           cfg_wr_en;
    logic [apm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [apm_pkg::CFG_DATA_W-1:0] cfg_data;

    apm_item_if   item_bus ();
    apm_result_if result_bus ();

    audio_peak_level_meter_top #(
        .BAR_COLUMNS  (BAR_COLUMNS),
        .ALERT_FRAMES (ALERT_FRAMES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (item_bus),
        .results   (result_bus),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    apm_pkg::cfg_t cfg_now;
    logic [7:0]  frame_fill;
    logic [11:0] frame_max;
    logic [15:0] ms_elapsed;
    logic [2:0]  bar_col [BAR_COLUMNS];
    logic [7:0]  loud_run;
    logic [11:0] report_max;
    logic [31:0] loud_peak_total;
    logic [23:0] loud_frames;
    logic [39:0] amp_total;
    logic [31:0] sample_tally;

    apm_pkg::out_item_t readings_due [$];
    apm_pkg::out_item_t due;
    apm_pkg::out_item_t got;

    bit calm;
    bit hold_off_req;
    int mismatches;
    int readings_checked;
    int items_taken;
    int settings_used;
    int frames_seen;
    int reports_seen;
    int alerts_seen;
    int shifts_seen;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] capped_sum(input logic [63:0] a, input logic [63:0] b,
                                               input int w);
        logic [63:0] top;
        logic [63:0] s;
        top = (64'd1 << w) - 64'd1;
        s = a + b;
        return (s >= top) ? top : s;
    endfunction

    function automatic logic [apm_pkg::BAR_HEIGHTS_W-1:0] bar_word();
        logic [apm_pkg::BAR_HEIGHTS_W-1:0] w;
        w = '0;
        for (int i = 0; i < apm_pkg::SHOWN_BARS && i < BAR_COLUMNS; i++)
            w[3*i +: 3] = bar_col[i];
        return w;
    endfunction

    function automatic bit advance_meter(input apm_pkg::in_item_t it,
                                         output apm_pkg::out_item_t reading);
        logic [11:0] amp;
        logic [11:0] peak;
        logic [7:0]  flen;
        logic [2:0]  level;
        reading = '0;
        if (it.operation == apm_pkg::OP_TICK)
        begin
            if (ms_elapsed != 16'hFFFF)
                ms_elapsed = ms_elapsed + 16'd1;
            return 1'b0;
        end
        if (it.operation == apm_pkg::OP_REPORT)
        begin
            reading.result_kind  = apm_pkg::KIND_REPORT;
            reading.bar_heights  = bar_word();
            reading.report_peak  = report_max;
            reading.loud_sum     = loud_peak_total;
            reading.loud_count   = loud_frames;
            reading.sample_sum   = amp_total;
            reading.sample_count = sample_tally;
            report_max      = '0;
            loud_peak_total = '0;
            loud_frames     = '0;
            amp_total       = '0;
            sample_tally    = '0;
            return 1'b1;
        end
        if (it.operation != apm_pkg::OP_SAMPLE)
            return 1'b0;

        amp = (it.sample >= cfg_now.silence_code) ? it.sample - cfg_now.silence_code
                                                  : cfg_now.silence_code - it.sample;
        flen = (cfg_now.frame_length == 8'd0) ? 8'd1 : cfg_now.frame_length;
        amp_total    = 40'(capped_sum(64'(amp_total), 64'(amp), 40));
        sample_tally = 32'(capped_sum(64'(sample_tally), 64'd1, 32));
        if (amp > frame_max)
            frame_max = amp;
        frame_fill = frame_fill + 8'd1;
        if (frame_fill < flen)
            return 1'b0;

        peak       = frame_max;
        frame_fill = '0;
        frame_max  = '0;
        if (peak > report_max)
            report_max = peak;

        if (peak < cfg_now.level_one_threshold)
            level = apm_pkg::LEVEL_QUIET;
        else if (peak < cfg_now.level_two_threshold)
            level = apm_pkg::LEVEL_ONE;
        else if (peak < cfg_now.level_three_threshold)
            level = apm_pkg::LEVEL_TWO;
        else if (peak < cfg_now.level_four_threshold)
            level = apm_pkg::LEVEL_THREE;
        else if (peak < cfg_now.loud_threshold)
            level = apm_pkg::LEVEL_FOUR;
        else
            level = apm_pkg::LEVEL_LOUD;

        if (level == apm_pkg::LEVEL_LOUD)
        begin
            loud_peak_total = 32'(capped_sum(64'(loud_peak_total), 64'(peak), 32));
            loud_frames     = 24'(capped_sum(64'(loud_frames), 64'd1, 24));
            loud_run        = loud_run + 8'd1;
            if (int'(loud_run) >= ALERT_FRAMES)
            begin
                reading.alert = 1'b1;
                loud_run      = '0;
            end
        end

        if (ms_elapsed >= cfg_now.bar_interval)
        begin
            for (int i = 0; i + 1 < BAR_COLUMNS; i++)
                bar_col[i] = bar_col[i+1];
            bar_col[BAR_COLUMNS-1] = level;
            ms_elapsed             = '0;
            reading.bars_updated   = 1'b1;
        end

        reading.result_kind = apm_pkg::KIND_FRAME;
        reading.frame_level = level;
        reading.frame_peak  = peak;
        reading.bar_heights = bar_word();
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = int'($urandom_range(0, 99));
        if (r < 65)
            return 0;
        if (r < 90)
            return int'($urandom_range(1, 3));
        if (r < 98)
            return int'($urandom_range(4, 10));
        return int'($urandom_range(20, 50));
    endfunction

    function automatic logic [11:0] pick_sample();
        int v;
        int thr;
        int sil;
        sil = int'(cfg_now.silence_code);
        thr = 0;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = 4095;
            2: v = sil + int'($urandom_range(0, 6)) - 3;
            3, 4:
            begin
                case ($urandom_range(0, 4))
                    0: thr = int'(cfg_now.level_one_threshold);
                    1: thr = int'(cfg_now.level_two_threshold);
                    2: thr = int'(cfg_now.level_three_threshold);
                    3: thr = int'(cfg_now.level_four_threshold);
                    default: thr = int'(cfg_now.loud_threshold);
                endcase
                v = thr + int'($urandom_range(0, 2)) - 1;
                v = ($urandom_range(0, 1) != 0) ? sil + v : sil - v;
            end
            default: v = int'($urandom_range(0, 4095));
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return 12'(v);
    endfunction

    function automatic apm_pkg::cfg_t random_setting(input bit ordered);
        apm_pkg::cfg_t s;
        if (ordered)
        begin
            s.silence_code          = 12'($urandom_range(1500, 2600));
            s.level_one_threshold   = 12'($urandom_range(0, 400));
            s.level_two_threshold   = s.level_one_threshold + 12'($urandom_range(0, 400));
            s.level_three_threshold = s.level_two_threshold + 12'($urandom_range(0, 400));
            s.level_four_threshold  = s.level_three_threshold + 12'($urandom_range(0, 400));
            s.loud_threshold        = s.level_four_threshold + 12'($urandom_range(0, 400));
        end
        else
        begin
            s.silence_code          = 12'($urandom_range(0, 4095));
            s.level_one_threshold   = 12'($urandom_range(0, 4095));
            s.level_two_threshold   = 12'($urandom_range(0, 4095));
            s.level_three_threshold = 12'($urandom_range(0, 4095));
            s.level_four_threshold  = 12'($urandom_range(0, 4095));
            s.loud_threshold        = 12'($urandom_range(0, 4095));
        end
        s.frame_length = 8'($urandom_range(1, 8));
        s.bar_interval = 16'($urandom_range(0, 5));
        return s;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] want);
        $display("result %0d, %s: got %0h, expected %0h", readings_checked, what, seen, want);
        mismatches++;
    endtask

    task automatic put_reg(input apm_pkg::reg_idx_e_t idx,
                           input logic [apm_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    task automatic apply_setting(input apm_pkg::cfg_t s);
        put_reg(apm_pkg::REG_SILENCE_CODE, {4'd0, s.silence_code});
        put_reg(apm_pkg::REG_LEVEL_ONE, {4'd0, s.level_one_threshold});
        put_reg(apm_pkg::REG_LEVEL_TWO, {4'd0, s.level_two_threshold});
        put_reg(apm_pkg::REG_LEVEL_THREE, {4'd0, s.level_three_threshold});
        put_reg(apm_pkg::REG_LEVEL_FOUR, {4'd0, s.level_four_threshold});
        put_reg(apm_pkg::REG_LOUD, {4'd0, s.loud_threshold});
        put_reg(apm_pkg::REG_FRAME_LENGTH, {8'd0, s.frame_length});
        put_reg(apm_pkg::REG_UPDATE_MS, s.bar_interval);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        cfg_now = s;
        settings_used++;
    endtask

    task automatic offer(input apm_pkg::in_item_t it, input bit pinned,
                         input apm_pkg::out_item_t pinned_reading);
        apm_pkg::out_item_t reading;
        int gap;
        item_bus.valid   <= 1'b1;
        item_bus.payload <= it;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        if (advance_meter(it, reading))
            readings_due.push_back(pinned ? pinned_reading : reading);
        items_taken++;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic run_mix(input int n, input int tick_pct);
        int taken;
        int r;
        apm_pkg::in_item_t it;
        taken = 0;
        while (taken < n)
        begin
            r = int'($urandom_range(0, 99));
            it.sample = 12'($urandom_range(0, 4095));
            if (r < tick_pct)
                it.operation = apm_pkg::OP_TICK;
            else if (r < tick_pct + 6)
                it.operation = apm_pkg::OP_REPORT;
            else if (r < tick_pct + 8)
                it.operation = apm_pkg::OP_UNUSED;
            else
            begin
                it.operation = apm_pkg::OP_SAMPLE;
                it.sample    = pick_sample();
            end
            offer(it, 1'b0, NO_PIN);
            if (it.operation != apm_pkg::OP_UNUSED)
                taken++;
        end
    endtask

    task automatic settle();
        item_bus.valid <= 1'b0;
        while (readings_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin : result_sink
        int stall_left;
        result_bus.ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0)
            begin
                if (hold_off_req)
                begin
                    stall_left   = LONG_HOLD;
                    hold_off_req = 1'b0;
                end
                else
                    stall_left = pick_gap();
            end
            if (stall_left > 0)
            begin
                result_bus.ready <= 1'b0;
                stall_left--;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : reading_checker
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got = result_bus.payload;
            if (readings_due.size() == 0)
                note_mismatch("result with none pending, kind", 64'(got.result_kind), 64'd0);
            else
            begin
                due = readings_due.pop_front();
                if (got.result_kind !== due.result_kind)
                    note_mismatch("result_kind", 64'(got.result_kind), 64'(due.result_kind));
                if (got.frame_level !== due.frame_level)
                    note_mismatch("frame_level", 64'(got.frame_level), 64'(due.frame_level));
                if (got.frame_peak !== due.frame_peak)
                    note_mismatch("frame_peak", 64'(got.frame_peak), 64'(due.frame_peak));
                if (got.alert !== due.alert)
                    note_mismatch("alert", 64'(got.alert), 64'(due.alert));
                if (got.bars_updated !== due.bars_updated)
                    note_mismatch("bars_updated", 64'(got.bars_updated), 64'(due.bars_updated));
                if (got.bar_heights !== due.bar_heights)
                    note_mismatch("bar_heights", 64'(got.bar_heights), 64'(due.bar_heights));
                if (got.report_peak !== due.report_peak)
                    note_mismatch("report_peak", 64'(got.report_peak), 64'(due.report_peak));
                if (got.loud_sum !== due.loud_sum)
                    note_mismatch("loud_sum", 64'(got.loud_sum), 64'(due.loud_sum));
                if (got.loud_count !== due.loud_count)
                    note_mismatch("loud_count", 64'(got.loud_count), 64'(due.loud_count));
                if (got.sample_sum !== due.sample_sum)
                    note_mismatch("sample_sum", 64'(got.sample_sum), 64'(due.sample_sum));
                if (got.sample_count !== due.sample_count)
                    note_mismatch("sample_count", 64'(got.sample_count), 64'(due.sample_count));
                if (due.result_kind == apm_pkg::KIND_REPORT)
                    reports_seen++;
                else
                    frames_seen++;
                if (due.alert)
                    alerts_seen++;
                if (due.bars_updated)
                    shifts_seen++;
            end
            readings_checked++;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t          directed_rows [$];
        apm_pkg::out_item_t empty_report;
        apm_pkg::out_item_t quiet_frame;
        apm_pkg::out_item_t loud_frame;
        apm_pkg::cfg_t      setting;

        rst_n            = 1'b0;
        item_bus.valid   = 1'b0;
        item_bus.payload = '0;
        cfg_wr_en        = 1'b0;
        cfg_index        = apm_pkg::REG_SILENCE_CODE;
        cfg_data         = '0;
        calm             = 1'b0;
        hold_off_req     = 1'b0;
        cfg_now          = FACTORY_SETTING;
        frame_fill       = '0;
        frame_max        = '0;
        ms_elapsed       = '0;
        loud_run         = '0;
        report_max       = '0;
        loud_peak_total  = '0;
        loud_frames      = '0;
        amp_total        = '0;
        sample_tally     = '0;
        foreach (bar_col[i])
            bar_col[i] = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        setting = FACTORY_SETTING;
        setting.frame_length = 8'd1;
        setting.bar_interval = 16'd0;
        apply_setting(setting);

        empty_report             = '0;
        empty_report.result_kind = apm_pkg::KIND_REPORT;
        quiet_frame              = '0;
        quiet_frame.bars_updated = 1'b1;
        loud_frame               = '0;
        loud_frame.frame_level   = apm_pkg::LEVEL_LOUD;
        loud_frame.frame_peak    = 12'd2048;
        loud_frame.bars_updated  = 1'b1;
        loud_frame.bar_heights   = {apm_pkg::LEVEL_LOUD, 12'd0};

        directed_rows = '{
            {apm_pkg::OP_REPORT, 12'd0, 1'b1, empty_report},
            {apm_pkg::OP_SAMPLE, SILENCE_MID, 1'b1, quiet_frame},
            {apm_pkg::OP_SAMPLE, 12'd0, 1'b1, loud_frame},
            {apm_pkg::OP_SAMPLE, 12'd4095, 1'b0, NO_PIN},
            {apm_pkg::OP_SAMPLE, SILENCE_MID + 12'd99, 1'b0, NO_PIN},
            {apm_pkg::OP_SAMPLE, SILENCE_MID + 12'd100, 1'b0, NO_PIN},
            {apm_pkg::OP_SAMPLE, SILENCE_MID - 12'd249, 1'b0, NO_PIN},
            {apm_pkg::OP_SAMPLE, SILENCE_MID - 12'd250, 1'b0, NO_PIN},
            {apm_pkg::OP_SAMPLE, SILENCE_MID + 12'd350, 1'b0, NO_PIN},
            {apm_pkg::OP_SAMPLE, SILENCE_MID - 12'd449, 1'b0, NO_PIN},
            {apm_pkg::OP_SAMPLE, SILENCE_MID + 12'd450, 1'b0, NO_PIN},
            {apm_pkg::OP_SAMPLE, SILENCE_MID + 12'd749, 1'b0, NO_PIN},
            {apm_pkg::OP_SAMPLE, SILENCE_MID - 12'd750, 1'b0, NO_PIN},
            {apm_pkg::OP_TICK, 12'd0, 1'b0, NO_PIN},
            {apm_pkg::OP_TICK, 12'd4095, 1'b0, NO_PIN},
            {apm_pkg::OP_UNUSED, 12'd4095, 1'b0, NO_PIN},
            {apm_pkg::OP_REPORT, 12'd0, 1'b0, NO_PIN},
            {apm_pkg::OP_SAMPLE, 12'hAAA, 1'b0, NO_PIN},
            {apm_pkg::OP_SAMPLE, 12'h555, 1'b0, NO_PIN},
            {apm_pkg::OP_REPORT, 12'd0, 1'b0, NO_PIN},
            {apm_pkg::OP_TICK, 12'd0, 1'b0, NO_PIN},
            {apm_pkg::OP_SAMPLE, SILENCE_MID, 1'b0, NO_PIN}
        };
        foreach (directed_rows[i])
            offer(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].reading);
        settle();

        apply_setting(FACTORY_SETTING);
        run_mix(250, 30);
        settle();

        // hold results back while items keep coming
        apply_setting('0);
        calm         = 1'b1;
        hold_off_req = 1'b1;
        run_mix(200, 10);
        settle();
        calm = 1'b0;

        apply_setting('1);
        run_mix(250, 5);
        settle();

        setting = random_setting(1'b0);
        setting.frame_length = 8'd0;
        setting.bar_interval = 16'd0;
        apply_setting(setting);
        run_mix(150, 15);
        settle();

        for (int p = 0; p < 3; p++)
        begin
            apply_setting(random_setting(1'b1));
            calm = (p == 1);
            run_mix(130, 25);
            settle();
            calm = 1'b0;
        end

        $display("Run covered %0d items under %0d register settings, %0d results checked.",
                 items_taken, settings_used, readings_checked);
        $display("Results held %0d frames, %0d reports, %0d loud alerts and %0d bar shifts.",
                 frames_seen, reports_seen, alerts_seen, shifts_seen);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/apm_pkg.sv
src/apm_if.sv
src/apm_front.sv
src/apm_queue.sv
src/apm_back.sv
src/audio_peak_level_meter_top.sv
dv/tb_top.sv
